// ===== hw/rtl/rcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// shared types and constants of the reference counted object cache
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int CAPACITY   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = 5;
    localparam int KEY_W      = 32;
    localparam int HND_W      = 32;
    localparam int REF_W      = 16;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_GET    = 3'd1,
        FN_LOOKUP = 3'd2,
        FN_FORGET = 3'd3,
        FN_HAVE   = 3'd4,
        FN_SHRINK = 3'd5,
        FN_CLEAR  = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE,
        S_EXEC,
        S_EVICT,
        S_CLEAR,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic resolve;
        logic exec;
        logic evict;
        logic clear_step;
        logic clear_fin;
        logic final_out;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              evict_more;
        logic              clear_more;
    } t_sts;

endpackage

// ===== hw/rtl/rcc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_ctrl
// sequencer: match, resolve, execute, release walk, final word
// ----------------------------------------------------------------------------
module rcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rcc_pkg::t_sts i_sts,
    output rcc_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    rcc_pkg::t_state r_state;
    rcc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcc_pkg::S_IDLE: begin
                if (i_start) n_state = rcc_pkg::S_MATCH;
            end
            rcc_pkg::S_MATCH:   n_state = rcc_pkg::S_RESOLVE;
            rcc_pkg::S_RESOLVE: n_state = rcc_pkg::S_EXEC;
            rcc_pkg::S_EXEC: begin
                if (i_sts.func == rcc_pkg::FN_SHRINK) n_state = rcc_pkg::S_EVICT;
                else if (i_sts.func == rcc_pkg::FN_CLEAR) n_state = rcc_pkg::S_CLEAR;
                else n_state = rcc_pkg::S_FINAL;
            end
            rcc_pkg::S_EVICT: begin
                if (!i_sts.evict_more) n_state = rcc_pkg::S_FINAL;
            end
            rcc_pkg::S_CLEAR: begin
                if (!i_sts.clear_more) n_state = rcc_pkg::S_FINAL;
            end
            rcc_pkg::S_FINAL: n_state = rcc_pkg::S_IDLE;
            default:          n_state = rcc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            rcc_pkg::S_IDLE: begin
                o_busy         = 1'b0;
                o_cmd.capture  = i_start;
            end
            rcc_pkg::S_MATCH:   o_cmd.match   = 1'b1;
            rcc_pkg::S_RESOLVE: o_cmd.resolve = 1'b1;
            rcc_pkg::S_EXEC:    o_cmd.exec    = 1'b1;
            rcc_pkg::S_EVICT:   o_cmd.evict   = i_sts.evict_more;
            rcc_pkg::S_CLEAR: begin
                o_cmd.clear_step = i_sts.clear_more;
                o_cmd.clear_fin  = !i_sts.clear_more;
            end
            rcc_pkg::S_FINAL:   o_cmd.final_out = 1'b1;
            default:            o_busy = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/rcc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_dp
// entry table, unused queue, counters and result word register
// ----------------------------------------------------------------------------
module rcc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rcc_pkg::t_cmd                      i_cmd,
    output rcc_pkg::t_sts                      o_sts,
    input  logic [rcc_pkg::FUNC_W-1:0]         i_func,
    input  logic [rcc_pkg::KEY_W-1:0]          i_key,
    input  logic [rcc_pkg::HND_W-1:0]          i_handle,
    input  logic                               i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic [rcc_pkg::STATUS_W-1:0]       o_status,
    output logic [rcc_pkg::HND_W-1:0]          o_value,
    output logic                               o_is_release,
    output logic                               o_last,
    output logic [rcc_pkg::CNT_W-1:0]          o_entry_total,
    output logic [rcc_pkg::CNT_W-1:0]          o_active_total,
    output logic [rcc_pkg::CNT_W-1:0]          o_limit_now
);

    localparam int CAP = rcc_pkg::CAPACITY;
    localparam int IW  = rcc_pkg::IDX_W;
    localparam int CW  = rcc_pkg::CNT_W;

    // table
    logic [CAP-1:0]              r_valid;
    logic [rcc_pkg::KEY_W-1:0]   r_key   [CAP];
    logic [rcc_pkg::HND_W-1:0]   r_hnd   [CAP];
    logic [rcc_pkg::REF_W-1:0]   r_refs  [CAP];
    logic [IW-1:0]               r_age   [CAP];
    logic [IW-1:0]               r_q     [CAP];
    logic [CW-1:0]               r_unused;
    logic [CW-1:0]               r_entry;
    logic [CW-1:0]               r_active;
    logic [CW-1:0]               r_limit;
    logic [CW-1:0]               r_lim_set;
    logic                        r_rel_en;

    // operation
    rcc_pkg::t_func              r_func;
    logic [rcc_pkg::KEY_W-1:0]   r_in_key;
    logic [rcc_pkg::HND_W-1:0]   r_in_hnd;
    logic [CAP-1:0]              r_kmatch;
    logic [CAP-1:0]              r_hmatch;
    logic                        r_khit;
    logic [IW-1:0]               r_kidx;
    logic                        r_hhit;
    logic [IW-1:0]               r_hidx;
    logic                        r_free_ok;
    logic [IW-1:0]               r_free_idx;
    logic [CW-1:0]               r_evict_left;
    logic [rcc_pkg::STATUS_W-1:0] r_status;
    logic [rcc_pkg::HND_W-1:0]   r_value;
    logic [CW-1:0]               r_tot_entry;
    logic [CW-1:0]               r_tot_active;
    logic [CW-1:0]               r_tot_limit;

    // result word
    logic                        r_o_strobe;
    logic [rcc_pkg::STATUS_W-1:0] r_o_status;
    logic [rcc_pkg::HND_W-1:0]   r_o_value;
    logic                        r_o_rel;
    logic                        r_o_last;

    // resolve logic
    logic                        n_khit;
    logic [IW-1:0]               n_kidx;
    logic                        n_hhit;
    logic [IW-1:0]               n_hidx;
    logic                        n_free_ok;
    logic [IW-1:0]               n_free_idx;
    logic                        newest;

    always_comb begin
        n_khit     = 1'b0;
        n_kidx     = '0;
        n_hhit     = 1'b0;
        n_hidx     = '0;
        n_free_ok  = 1'b0;
        n_free_idx = '0;
        newest     = 1'b0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (r_kmatch[i]) begin
                n_khit = 1'b1;
                n_kidx = IW'(i);
            end
            if (!r_valid[i]) begin
                n_free_ok  = 1'b1;
                n_free_idx = IW'(i);
            end
        end
        // newest match: every other match is older
        for (int i = 0; i < CAP; i++) begin
            newest = r_hmatch[i];
            for (int j = 0; j < CAP; j++) begin
                if (j != i && r_hmatch[j] && !(r_age[j] > r_age[i])) newest = 1'b0;
            end
            if (newest) begin
                n_hhit = 1'b1;
                n_hidx = IW'(i);
            end
        end
    end

    // shrink arithmetic and queue position for get
    logic                        autogrow;
    logic [CW-1:0]               shr_lim;
    logic [CW-1:0]               shr_diff;
    logic [CW-1:0]               shr_cnt;
    logic                        q_found;
    logic [IW-1:0]               q_pos;
    logic [CW-1:0]               add_act;

    always_comb begin
        autogrow = (r_lim_set == '0);
        if (autogrow && ({1'b0, r_limit} > {r_active, 1'b0})) begin
            shr_lim = r_active + (r_active >> 1);
        end else begin
            shr_lim = r_limit;
        end
        shr_diff = r_entry - shr_lim;
        if (r_entry > shr_lim) begin
            shr_cnt = (shr_diff < r_unused) ? shr_diff : r_unused;
        end else begin
            shr_cnt = '0;
        end
        q_found = 1'b0;
        q_pos   = '0;
        for (int j = CAP - 1; j >= 0; j--) begin
            if (CW'(j) < r_unused && r_q[j] == r_kidx) begin
                q_found = 1'b1;
                q_pos   = IW'(j);
            end
        end
        add_act = r_active + CW'(1);
    end

    logic [IW-1:0] head;
    assign head = r_q[0];

    assign o_sts.func       = r_func;
    assign o_sts.evict_more = (r_evict_left != '0);
    assign o_sts.clear_more = (r_unused != '0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_unused   <= '0;
            r_entry    <= '0;
            r_active   <= '0;
            r_limit    <= '0;
            r_lim_set  <= '0;
            r_rel_en   <= 1'b1;
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rcc_pkg::CFG_LIMIT: begin
                        r_lim_set <= i_cfg_data;
                        r_limit   <= i_cfg_data;
                    end
                    rcc_pkg::CFG_RELEASE: r_rel_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                case (r_func)
                    rcc_pkg::FN_ADD: begin
                        if (!r_khit && r_free_ok) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_entry  <= r_entry + CW'(1);
                            r_active <= add_act;
                            if (autogrow && add_act > r_limit) r_limit <= add_act;
                        end
                    end
                    rcc_pkg::FN_GET: begin
                        if (r_khit && r_refs[r_kidx] == '0) begin
                            r_active <= add_act;
                            if (q_found) r_unused <= r_unused - CW'(1);
                        end
                    end
                    rcc_pkg::FN_FORGET: begin
                        if (r_hhit && r_refs[r_hidx] == rcc_pkg::REF_W'(1)) begin
                            if (r_active != '0) r_active <= r_active - CW'(1);
                            if (r_unused < CW'(CAP)) r_unused <= r_unused + CW'(1);
                        end
                    end
                    rcc_pkg::FN_SHRINK: r_limit <= shr_lim;
                    default: ;
                endcase
            end
            if (i_cmd.evict) begin
                r_valid[head] <= 1'b0;
                r_entry       <= r_entry - CW'(1);
                r_unused      <= r_unused - CW'(1);
                r_o_strobe    <= r_rel_en;
            end
            if (i_cmd.clear_step) begin
                r_unused   <= r_unused - CW'(1);
                r_o_strobe <= r_rel_en && r_valid[head];
            end
            if (i_cmd.clear_fin) begin
                r_valid  <= '0;
                r_entry  <= '0;
                r_active <= '0;
            end
            if (i_cmd.final_out) r_o_strobe <= 1'b1;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= rcc_pkg::t_func'(i_func);
            r_in_key <= i_key;
            r_in_hnd <= i_handle;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < CAP; i++) begin
                r_kmatch[i] <= r_valid[i] && (r_key[i] == r_in_key);
                r_hmatch[i] <= r_valid[i] && (r_hnd[i] == r_in_hnd) && (r_in_hnd != '0);
            end
        end
        if (i_cmd.resolve) begin
            r_khit     <= n_khit;
            r_kidx     <= n_kidx;
            r_hhit     <= n_hhit;
            r_hidx     <= n_hidx;
            r_free_ok  <= n_free_ok;
            r_free_idx <= n_free_idx;
        end
        if (i_cmd.exec) begin
            r_status     <= rcc_pkg::ST_OK;
            r_value      <= '0;
            r_evict_left <= '0;
            case (r_func)
                rcc_pkg::FN_ADD: begin
                    if (!r_khit) begin
                        if (!r_free_ok) begin
                            r_status <= rcc_pkg::ST_FULL;
                        end else begin
                            for (int i = 0; i < CAP; i++) begin
                                if (r_valid[i]) r_age[i] <= r_age[i] + IW'(1);
                            end
                            r_key[r_free_idx]  <= r_in_key;
                            r_hnd[r_free_idx]  <= r_in_hnd;
                            r_refs[r_free_idx] <= rcc_pkg::REF_W'(1);
                            r_age[r_free_idx]  <= '0;
                        end
                    end
                end
                rcc_pkg::FN_GET: begin
                    if (!r_khit) begin
                        r_status <= rcc_pkg::ST_MISS;
                    end else begin
                        r_value <= r_hnd[r_kidx];
                        if (r_refs[r_kidx] == '0) begin
                            r_refs[r_kidx] <= rcc_pkg::REF_W'(1);
                            // close the gap left in the unused queue
                            if (q_found) begin
                                for (int j = 0; j < CAP - 1; j++) begin
                                    if (IW'(j) >= q_pos) r_q[j] <= r_q[j+1];
                                end
                            end
                        end else if (r_refs[r_kidx] != '1) begin
                            r_refs[r_kidx] <= r_refs[r_kidx] + rcc_pkg::REF_W'(1);
                        end
                    end
                end
                rcc_pkg::FN_LOOKUP: begin
                    if (!r_khit) r_status <= rcc_pkg::ST_MISS;
                    else r_value <= r_hnd[r_kidx];
                end
                rcc_pkg::FN_FORGET: begin
                    if (!r_hhit || r_refs[r_hidx] == '0) begin
                        r_status <= rcc_pkg::ST_MISS;
                    end else begin
                        r_refs[r_hidx] <= r_refs[r_hidx] - rcc_pkg::REF_W'(1);
                        if (r_refs[r_hidx] == rcc_pkg::REF_W'(1) && r_unused < CW'(CAP)) begin
                            r_q[r_unused[IW-1:0]] <= r_hidx;
                        end
                    end
                end
                rcc_pkg::FN_HAVE: begin
                    if (!r_hhit) r_status <= rcc_pkg::ST_MISS;
                end
                rcc_pkg::FN_SHRINK: r_evict_left <= shr_cnt;
                rcc_pkg::FN_CLEAR: ;
                default: r_status <= rcc_pkg::ST_MISS;
            endcase
        end
        // totals after the whole operation, shared by all its words
        if (i_cmd.exec) begin
            case (r_func)
                rcc_pkg::FN_ADD: begin
                    if (!r_khit && r_free_ok) begin
                        r_tot_entry  <= r_entry + CW'(1);
                        r_tot_active <= add_act;
                        r_tot_limit  <= (autogrow && add_act > r_limit) ? add_act : r_limit;
                    end else begin
                        r_tot_entry  <= r_entry;
                        r_tot_active <= r_active;
                        r_tot_limit  <= r_limit;
                    end
                end
                rcc_pkg::FN_GET: begin
                    r_tot_entry  <= r_entry;
                    r_tot_active <= (r_khit && r_refs[r_kidx] == '0) ? add_act : r_active;
                    r_tot_limit  <= r_limit;
                end
                rcc_pkg::FN_FORGET: begin
                    r_tot_entry  <= r_entry;
                    r_tot_active <= (r_hhit && r_refs[r_hidx] == rcc_pkg::REF_W'(1) &&
                                     r_active != '0) ? r_active - CW'(1) : r_active;
                    r_tot_limit  <= r_limit;
                end
                rcc_pkg::FN_SHRINK: begin
                    r_tot_entry  <= r_entry - shr_cnt;
                    r_tot_active <= r_active;
                    r_tot_limit  <= shr_lim;
                end
                rcc_pkg::FN_CLEAR: begin
                    r_tot_entry  <= '0;
                    r_tot_active <= '0;
                    r_tot_limit  <= r_limit;
                end
                default: begin
                    r_tot_entry  <= r_entry;
                    r_tot_active <= r_active;
                    r_tot_limit  <= r_limit;
                end
            endcase
        end
        if (i_cmd.evict) begin
            for (int i = 0; i < CAP; i++) begin
                if (r_valid[i] && r_age[i] > r_age[head]) r_age[i] <= r_age[i] - IW'(1);
            end
            r_evict_left <= r_evict_left - CW'(1);
        end
        if (i_cmd.evict || i_cmd.clear_step) begin
            for (int j = 0; j < CAP - 1; j++) r_q[j] <= r_q[j+1];
            r_o_status <= rcc_pkg::ST_OK;
            r_o_value  <= r_hnd[head];
            r_o_rel    <= 1'b1;
            r_o_last   <= 1'b0;
        end
        if (i_cmd.final_out) begin
            r_o_status <= r_status;
            r_o_value  <= r_value;
            r_o_rel    <= 1'b0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_strobe       = r_o_strobe;
    assign o_status       = r_o_status;
    assign o_value        = r_o_value;
    assign o_is_release   = r_o_rel;
    assign o_last         = r_o_last;
    assign o_entry_total  = r_tot_entry;
    assign o_active_total = r_tot_active;
    assign o_limit_now    = r_tot_limit;

endmodule

// ===== hw/rtl/refcounted_object_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_object_cache
// reference counted key/handle table with oldest-first eviction of unused entries
// ----------------------------------------------------------------------------
// sequence: after start, the match, resolve and execute states, then the final
// state; shrink and clear walk the unused queue between execute and final, one
// entry per step (up to 16), clear with a closing step that empties the table
// operations: one at a time, next start taken in the cycle the final word is shown
// reset: synchronous active low, empties the table, limit 0, release on
// results are shown one cycle each by o_strobe; the receiver cannot stall
module refcounted_object_cache (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rcc_pkg::FUNC_W-1:0]         i_func,
    input  logic [rcc_pkg::KEY_W-1:0]          i_key,
    input  logic [rcc_pkg::HND_W-1:0]          i_handle,
    input  logic                               i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic [rcc_pkg::STATUS_W-1:0]       o_status,
    output logic [rcc_pkg::HND_W-1:0]          o_value,
    output logic                               o_is_release,
    output logic                               o_last,
    output logic [rcc_pkg::CNT_W-1:0]          o_entry_total,
    output logic [rcc_pkg::CNT_W-1:0]          o_active_total,
    output logic [rcc_pkg::CNT_W-1:0]          o_limit_now
);

    // command and status between sequencer and datapath
    rcc_pkg::t_cmd cmd;
    rcc_pkg::t_sts sts;

    // sequencer: steps each operation, walks the unused queue for shrink/clear
    rcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: parallel key and handle match over the table, counters,
    // unused queue as a shift line, result word register
    rcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_handle       (i_handle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_is_release   (o_is_release),
        .o_last         (o_last),
        .o_entry_total  (o_entry_total),
        .o_active_total (o_active_total),
        .o_limit_now    (o_limit_now)
    );

endmodule
